// ----- rtl/unsigned_decimal_ascii_emitter_core_macros.svh -----
// Assertion macros for the decimal ASCII emitter core.
// Used by unsigned_decimal_ascii_emitter_core.sv; needs clk and arst_n in scope.
`ifndef UNSIGNED_DECIMAL_ASCII_EMITTER_CORE_MACROS_SVH
`define UNSIGNED_DECIMAL_ASCII_EMITTER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define UDAE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define UDAE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/udae_pkg.sv -----
// Shared types and character codes for the decimal ASCII emitter.
// No dependencies.
package udae_pkg;

	localparam int CHAR_W = 6;

	typedef logic [3:0]        bcd_digit_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t CHAR_ZERO    = 6'd48;
	localparam char_t CHAR_NINE    = 6'd57;
	localparam char_t CHAR_NEWLINE = 6'd10;

endpackage

// ----- rtl/unsigned_decimal_ascii_emitter_core.sv -----
// Channel  | Dir | Signals                      | Item
// s        | in  | s_tvalid s_tready s_tdata    | one unsigned value
// m        | out | m_tvalid m_tready m_tdata    | one ASCII character, tlast on newline
//
// Steps: take a value, then bit-serial double dabble over all VALUE_BITS input bits (one
// input bit shifted into the BCD register per cycle), then drop leading zeros, then emit
// the digits, most significant first, and last the newline.
// Reset (arst_n, async low) clears the sequencer and the output valid.
// A stalled output holds its character; the sequencer waits, and the next value is
// taken as soon as the newline sits in the output register.
// Depends on udae_pkg and unsigned_decimal_ascii_emitter_core_macros.svh.
`include "unsigned_decimal_ascii_emitter_core_macros.svh"

module unsigned_decimal_ascii_emitter_core #(
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
	output logic        m_tlast    // last
);

	// Decimal digits of 2^VALUE_BITS-1: floor(VALUE_BITS*log10(2))+1
	localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int BCD_W  = DIGITS * 4;
	localparam int BIT_CW = $clog2(VALUE_BITS + 1);
	localparam int DIG_CW = $clog2(DIGITS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_NL   = 3'd4;

	logic [2:0]            state_q;
	logic [BIT_CW-1:0]     bit_cnt_q;
	logic [DIG_CW-1:0]     dig_cnt_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	udae_pkg::bcd_digit_t  top_digit;
	udae_pkg::char_t       char_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  load_digit;
	logic                  load_nl;

	// Add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign top_digit  = bcd_q[BCD_W-1 -: 4];
	assign out_free   = !out_valid_q || m_tready;
	assign load_digit = (state_q == ST_EMIT) && out_free;
	assign load_nl    = (state_q == ST_NL) && out_free;
	assign s_tready   = (state_q == ST_IDLE);

	// Sequence: take value, convert, drop leading zeros, emit digits, emit newline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						bit_cnt_q <= BIT_CW'(VALUE_BITS);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == BIT_CW'(1)) begin
						dig_cnt_q <= DIG_CW'(DIGITS);
						state_q   <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit == 4'd0 && dig_cnt_q > DIG_CW'(1)) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
						if (dig_cnt_q == DIG_CW'(1)) begin
							state_q <= ST_NL;
						end
					end
				end
				ST_NL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath shift registers: binary out at the top, BCD digits out at the top
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			bin_q <= s_tdata[VALUE_BITS-1:0];
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
		end else if ((state_q == ST_SKIP && top_digit == 4'd0 && dig_cnt_q > DIG_CW'(1))
				|| load_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_digit || load_nl) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_digit) begin
			char_q <= udae_pkg::CHAR_ZERO + udae_pkg::char_t'(top_digit);
			last_q <= 1'b0;
		end else if (load_nl) begin
			char_q <= udae_pkg::CHAR_NEWLINE;
			last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, char_q};
	assign m_tlast  = last_q;

	// Checks
	`UDAE_ASSERT_NOW(a_nl_last, m_tvalid && m_tlast, m_tdata[5:0] == udae_pkg::CHAR_NEWLINE, "newline item has wrong character")
	`UDAE_ASSERT_NOW(a_digit_range, m_tvalid && !m_tlast, m_tdata[5:0] >= udae_pkg::CHAR_ZERO && m_tdata[5:0] <= udae_pkg::CHAR_NINE, "digit item out of range")
	`UDAE_ASSERT_NOW(a_emit_count, state_q == ST_EMIT, dig_cnt_q != '0, "emit with no digits left")
	`UDAE_ASSERT_NEXT(a_conv_done, state_q == ST_CONV && bit_cnt_q == BIT_CW'(1), state_q == ST_SKIP, "conversion did not finish")

endmodule

// ----- test/testbench.sv -----
// Stream-level testbench for unsigned_decimal_ascii_emitter_core: sends 64-bit values and
// checks each ASCII digit/newline item against an in-bench decimal conversion.
// Depends on udae_pkg and the core RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_BITS     = 64;
	localparam int DRAIN_CYCLES   = VALUE_BITS + 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		udae_pkg::char_t code;
		logic            is_last;
	} ascii_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	ascii_item_t pending_chars[$];
	int          fail_count    = 0;
	int          idle_cycles   = 0;
	bit          idling        = 1'b1;
	bit          hold_request  = 1'b0;

	unsigned_decimal_ascii_emitter_core #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [63:0] value
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // [5:0] character, [7:6] zero
		.m_tlast  (m_tlast)     // last
	);

	always #1 clk = ~clk;

	// Queue the decimal digits of one value, most significant first, then the newline
	function automatic void queue_decimal_chars(input logic [63:0] raw);
		logic [63:0]     mask;
		logic [63:0]     v;
		udae_pkg::char_t digits[$];
		ascii_item_t     item;

		mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
		v = raw & mask;
		do begin
			digits.push_front(udae_pkg::CHAR_ZERO + udae_pkg::char_t'(v % 64'd10));
			v = v / 64'd10;
		end while (v != 64'd0);
		foreach (digits[i]) begin
			item.code    = digits[i];
			item.is_last = 1'b0;
			pending_chars.push_back(item);
		end
		item.code    = udae_pkg::CHAR_NEWLINE;
		item.is_last = 1'b1;
		pending_chars.push_back(item);
	endfunction

	// Random value: mostly random bit lengths, some full width, some near powers of ten
	function automatic logic [63:0] random_value();
		logic [63:0] v;
		logic [63:0] p;
		int          pick;
		int          nbits;

		v     = {$urandom, $urandom};
		pick  = $urandom_range(0, 9);
		nbits = $urandom_range(1, 64);
		if (pick == 0) begin
			p = 64'd1;
			repeat ($urandom_range(0, 19)) p = p * 64'd10;
			v = p - 64'($urandom_range(0, 1));
		end else if (pick >= 3 && nbits < 64) begin
			v = v & ((64'd1 << nbits) - 64'd1);
		end
		return v;
	endfunction

	// Offer one item, hold it until accepted, then record its expected characters
	task automatic send_value(input logic [63:0] v);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		queue_decimal_chars(v);
	endtask

	// Stop offering and wait until every expected character has come out
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed_values();
		logic [63:0] vals[$];

		vals = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd999999999,
			64'd1000000000, 64'hFFFF_FFFF, 64'h1_0000_0000,
			64'd9999999999999999999, 64'd10000000000000000000,
			64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			64'd1234567890123456789, 64'd18446744073709551614};
		foreach (vals[i]) send_value(vals[i]);
	endtask

	task automatic test_random_values(input int count);
		repeat (count) send_value(random_value());
	endtask

	// Hold the output off for a long stretch while input keeps coming
	task automatic test_output_backpressure();
		hold_request = 1'b1;
		repeat (25) send_value(random_value());
	endtask

	// Receiver: random ready bursts, one long hold on request
	initial begin
		@(posedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Compare each output item with the oldest expectation
	always @(posedge clk) begin
		ascii_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected item: tdata=%0d tlast=%0b", m_tdata, m_tlast);
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata !== {2'b00, want.code} || m_tlast !== want.is_last) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("mismatch: expected tdata=%0d tlast=%0b, got tdata=%0d tlast=%0b",
							{2'b00, want.code}, want.is_last, m_tdata, m_tlast);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_values();
		test_random_values(100);
		test_output_backpressure();
		drain_outputs();
		test_random_values(30);
		idling = 1'b0;
		test_random_values(40);
		drain_outputs();
		if (pending_chars.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
